### rtl/core/cctv_pkg.sv
// ----------------------------------------------------------------------------
// cctv_pkg
// types, constants and helpers shared by the chunk hash tracker modules
// ----------------------------------------------------------------------------
`default_nettype none

package cctv_pkg;

    localparam int unsigned DEF_MAX_CHUNKS = 256;

    localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
    localparam logic [31:0] RAM_BASE  = 32'h8000_0000;
    localparam logic [31:0] RAM_RESET = 32'd25165824;

    localparam logic [1:0] ST_UNVERIFIED = 2'd0;
    localparam logic [1:0] ST_VERIFIED   = 2'd1;
    localparam logic [1:0] ST_FAILED     = 2'd2;

    localparam logic [2:0] REQ_LOAD  = 3'd0;
    localparam logic [2:0] REQ_BEGIN = 3'd1;
    localparam logic [2:0] REQ_HASH  = 3'd2;
    localparam logic [2:0] REQ_INVAL = 3'd3;

    localparam logic [1:0] REG_ACTIVE = 2'd0;
    localparam logic [1:0] REG_COUNT  = 2'd1;
    localparam logic [1:0] REG_RAM    = 2'd2;

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_BEGIN,
        OP_HASH,
        OP_INVAL,
        OP_QUERY
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [7:0]  idx;
        logic [31:0] rstart;
        logic [31:0] rend;
        logic [31:0] len;
        logic [63:0] hash;
        logic [7:0]  data;
        logic        last;
    } t_cmd;

    typedef struct packed {
        logic        active;
        logic [8:0]  count;
        logic [31:0] ram_bytes;
    } t_cfg;

    typedef struct packed {
        logic valid;
        logic ready;
    } t_hs;

    // one fnv-1a step; prime is 2^40 + 0x1b3 so the product is a shift plus a narrow multiply
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x * 64'h1B3);
    endfunction

    // failure count follows every change into or out of failed
    function automatic logic [8:0] fail_adj(input logic [1:0] old_st, input logic [1:0] new_st,
                                            input logic [8:0] cnt);
        logic [8:0] r;
        r = cnt;
        if (old_st == ST_FAILED && new_st != ST_FAILED && cnt != 9'd0) r = cnt - 9'd1;
        if (old_st != ST_FAILED && new_st == ST_FAILED && cnt != 9'd511) r = cnt + 9'd1;
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/cctv_if.sv
// ----------------------------------------------------------------------------
// cctv_if
// request and response channel interfaces of the chunk hash tracker
// ----------------------------------------------------------------------------
`default_nettype none

interface cctv_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [7:0]  chunk_index;
    logic [31:0] range_start;
    logic [31:0] range_end;
    logic [31:0] inval_length;
    logic [63:0] expected_hash;
    logic [7:0]  data_byte;
    logic        last_byte;

    modport source (output valid, req_type, chunk_index, range_start, range_end,
                    inval_length, expected_hash, data_byte, last_byte, input ready);
    modport sink   (input valid, req_type, chunk_index, range_start, range_end,
                    inval_length, expected_hash, data_byte, last_byte, output ready);
endinterface

interface cctv_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  chunk_status;
    logic [8:0]  failed_total;
    logic [63:0] computed_hash;
    logic [8:0]  reset_chunks;

    modport source (output valid, chunk_status, failed_total, computed_hash, reset_chunks,
                    input ready);
    modport sink   (input valid, chunk_status, failed_total, computed_hash, reset_chunks,
                    output ready);
endinterface

`default_nettype wire

### rtl/core/code_chunk_hash_validation_tracker_core.sv
// ----------------------------------------------------------------------------
// code_chunk_hash_validation_tracker_core
// code chunk table with fnv-1a 64 verification and range invalidation
// ----------------------------------------------------------------------------
// channel   dir  handshake       payload
// i_req     in   valid/ready     req_type chunk_index range_start range_end
//                                inval_length expected_hash data_byte last_byte
// o_rsp     out  valid/ready     chunk_status failed_total computed_hash reset_chunks
// apb       in   psel/penable    paddr pwdata prdata, pready tied high
//
// load, begin, hash byte and query each pass through the sequencer steps
// (table read, update, response register); a 2-entry queue takes requests meanwhile
// invalidate: binary search probes, then a walk that reads each chunk in turn, then the
// response register; straight to the response register when inactive or of zero length
// reset clears control state and chunk state valid bits at once; no clearing pass
// a stalled response holds the sequencer in its final step, then the queue fills
`default_nettype none

module code_chunk_hash_validation_tracker_core
    import cctv_pkg::*;
#(
    parameter int unsigned MAX_CHUNKS = DEF_MAX_CHUNKS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    cctv_req_if.sink         i_req,
    cctv_rsp_if.source       o_rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    t_cfg r_cfg;
    t_cmd c_cmd;
    t_hs  c_hs;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active    <= 1'b0;
            r_cfg.count     <= 9'd0;
            r_cfg.ram_bytes <= RAM_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                REG_ACTIVE: r_cfg.active    <= pwdata[0];
                REG_COUNT:  r_cfg.count     <= pwdata[8:0];
                REG_RAM:    r_cfg.ram_bytes <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_ACTIVE: prdata = {31'd0, r_cfg.active};
            REG_COUNT:  prdata = {23'd0, r_cfg.count};
            REG_RAM:    prdata = r_cfg.ram_bytes;
            default:    prdata = 32'd0;
        endcase
    end

    cctv_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd       (c_cmd),
        .o_cmd_valid (c_hs.valid),
        .i_cmd_ready (c_hs.ready)
    );

    cctv_back #(
        .MAX_CHUNKS (MAX_CHUNKS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (c_cmd),
        .i_cmd_valid (c_hs.valid),
        .o_cmd_ready (c_hs.ready),
        .o_rsp       (o_rsp)
    );

endmodule

`default_nettype wire

### rtl/core/cctv_front.sv
// ----------------------------------------------------------------------------
// cctv_front
// accepts requests, decodes the request code and queues them for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module cctv_front
    import cctv_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cctv_req_if.sink   i_req,
    output t_cmd       o_cmd,
    output logic       o_cmd_valid,
    input  wire logic  i_cmd_ready
);

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       c_cmd;
    logic       c_push, c_pop;

    always_comb begin
        c_cmd.idx    = i_req.chunk_index;
        c_cmd.rstart = i_req.range_start;
        c_cmd.rend   = i_req.range_end;
        c_cmd.len    = i_req.inval_length;
        c_cmd.hash   = i_req.expected_hash;
        c_cmd.data   = i_req.data_byte;
        c_cmd.last   = i_req.last_byte;
        case (i_req.req_type)
            REQ_LOAD:  c_cmd.op = OP_LOAD;
            REQ_BEGIN: c_cmd.op = OP_BEGIN;
            REQ_HASH:  c_cmd.op = OP_HASH;
            REQ_INVAL: c_cmd.op = OP_INVAL;
            default:   c_cmd.op = OP_QUERY;
        endcase
    end

    assign i_req.ready = (r_cnt != 2'd2);
    assign c_push      = i_req.valid && i_req.ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign c_pop       = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (c_push) r_q[r_wp] <= c_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (c_push) r_wp <= ~r_wp;
            if (c_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, c_push} - {1'b0, c_pop};
        end
    end

endmodule

`default_nettype wire

### rtl/core/cctv_back.sv
// ----------------------------------------------------------------------------
// cctv_back
// chunk table memories, verify and invalidate sequencer, response register
// ----------------------------------------------------------------------------
`default_nettype none

module cctv_back
    import cctv_pkg::*;
#(
    parameter int unsigned MAX_CHUNKS = DEF_MAX_CHUNKS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire t_cmd  i_cmd,
    input  wire logic  i_cmd_valid,
    output logic       o_cmd_ready,
    cctv_rsp_if.source o_rsp
);

    localparam int unsigned AW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int unsigned CW = ($clog2(MAX_CHUNKS + 1) > 9) ? $clog2(MAX_CHUNKS + 1) : 9;
    localparam logic [CW-1:0] MAXC = CW'(MAX_CHUNKS);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DATA     = 7'b0000010,
        S_SRCH_RD  = 7'b0000100,
        S_SRCH_CMP = 7'b0001000,
        S_WALK_RD  = 7'b0010000,
        S_WALK_CHK = 7'b0100000,
        S_DONE     = 7'b1000000
    } t_state;

    logic [31:0] m_start [MAX_CHUNKS];
    logic [31:0] m_end   [MAX_CHUNKS];
    logic [63:0] m_hash  [MAX_CHUNKS];
    logic [1:0]  m_st    [MAX_CHUNKS];
    logic        r_vld   [MAX_CHUNKS];

    logic [31:0] rd_start, rd_end;
    logic [63:0] rd_hash;
    logic [1:0]  rd_st;
    logic        rd_vld;
    logic [1:0]  c_old;

    t_state      r_state, n_state;
    t_cmd        r_cmd, n_cmd;
    logic [8:0]  r_fail, n_fail;
    logic [63:0] r_acc, n_acc;
    logic [AW-1:0] r_vchunk, n_vchunk;
    logic        r_busy, n_busy;
    logic        r_fin, n_fin;
    logic [CW-1:0] r_lo, n_lo, r_hi, n_hi, r_mid, n_mid;
    logic [31:0] r_lastaddr, n_lastaddr;
    logic [8:0]  r_resets, n_resets;
    logic [1:0]  r_status, n_status;
    logic        r_ov, n_ov;
    logic [1:0]  r_o_st, n_o_st;
    logic [8:0]  r_o_fail, n_o_fail, r_o_rst, n_o_rst;
    logic [63:0] r_o_hash, n_o_hash;

    logic [AW-1:0] c_raddr, c_waddr;
    logic        c_we_load, c_we_hash, c_we_st;
    logic [63:0] c_whash;
    logic [1:0]  c_wst;
    logic [CW-1:0] c_n, c_idx;
    logic        c_inrange;
    logic [AW-1:0] c_addr;
    logic [31:0] c_off, c_clen;
    logic [1:0]  c_fst;

    assign c_n       = (CW'(i_cfg.count) > MAXC) ? MAXC : CW'(i_cfg.count);
    assign c_idx     = CW'(r_cmd.idx);
    assign c_inrange = c_idx < MAXC;
    assign c_addr    = AW'(c_idx);
    assign c_old     = rd_vld ? rd_st : ST_UNVERIFIED;
    assign c_off     = rd_start - RAM_BASE;
    assign c_clen    = rd_end - rd_start;

    always_ff @(posedge i_clk) begin
        rd_start <= m_start[c_raddr];
        rd_end   <= m_end[c_raddr];
        rd_hash  <= m_hash[c_raddr];
        rd_st    <= m_st[c_raddr];
        if (c_we_load) begin
            m_start[c_waddr] <= r_cmd.rstart;
            m_end[c_waddr]   <= r_cmd.rend;
        end
        if (c_we_load || c_we_hash) m_hash[c_waddr] <= c_whash;
        if (c_we_st) m_st[c_waddr] <= c_wst;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_CHUNKS; k++) r_vld[k] <= 1'b0;
            rd_vld <= 1'b0;
        end else begin
            rd_vld <= r_vld[c_raddr];
            if (c_we_st) r_vld[c_waddr] <= 1'b1;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_fail     = r_fail;
        n_acc      = r_acc;
        n_vchunk   = r_vchunk;
        n_busy     = r_busy;
        n_fin      = r_fin;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_mid      = r_mid;
        n_lastaddr = r_lastaddr;
        n_resets   = r_resets;
        n_status   = r_status;
        n_ov       = r_ov && !o_rsp.ready;
        n_o_st     = r_o_st;
        n_o_fail   = r_o_fail;
        n_o_rst    = r_o_rst;
        n_o_hash   = r_o_hash;
        c_raddr    = c_addr;
        c_waddr    = c_addr;
        c_we_load  = 1'b0;
        c_we_hash  = 1'b0;
        c_we_st    = 1'b0;
        c_whash    = r_cmd.hash;
        c_wst      = ST_UNVERIFIED;
        c_fst      = ST_UNVERIFIED;
        o_cmd_ready = (r_state == S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_cmd    = i_cmd;
                    n_resets = 9'd0;
                    n_status = ST_UNVERIFIED;
                    c_raddr  = AW'(CW'(i_cmd.idx));
                    n_state  = S_DATA;
                    case (i_cmd.op)
                        OP_HASH: begin
                            c_raddr = r_vchunk;
                            n_fin   = r_busy && i_cmd.last;
                            if (r_busy) n_acc = fnv_step(r_acc, i_cmd.data);
                        end
                        OP_INVAL: begin
                            if (i_cfg.active && i_cmd.len != 32'd0) begin
                                n_lo       = '0;
                                n_hi       = c_n;
                                n_lastaddr = i_cmd.rstart + (i_cmd.len - 32'd1);
                                n_state    = S_SRCH_RD;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DATA: begin
                n_state = S_DONE;
                case (r_cmd.op)
                    OP_LOAD: begin
                        if (c_inrange) begin
                            c_we_load = 1'b1;
                            c_we_st   = 1'b1;
                            c_wst     = ST_UNVERIFIED;
                            n_fail    = fail_adj(c_old, ST_UNVERIFIED, r_fail);
                        end
                        n_status = ST_UNVERIFIED;
                    end
                    OP_BEGIN: begin
                        n_status = c_inrange ? c_old : ST_UNVERIFIED;
                        if (c_inrange && c_idx < c_n) begin
                            n_acc  = FNV_BASIS;
                            n_busy = 1'b0;
                            if (rd_start < RAM_BASE || c_off >= i_cfg.ram_bytes ||
                                c_clen > i_cfg.ram_bytes - c_off) begin
                                c_we_st  = 1'b1;
                                c_wst    = ST_FAILED;
                                n_fail   = fail_adj(c_old, ST_FAILED, r_fail);
                                n_status = ST_FAILED;
                            end else if (c_clen == 32'd0) begin
                                if (rd_hash == 64'd0) begin
                                    c_we_hash = 1'b1;
                                    c_whash   = FNV_BASIS;
                                end
                                c_fst    = (rd_hash == 64'd0 || rd_hash == FNV_BASIS) ?
                                           ST_VERIFIED : ST_FAILED;
                                c_we_st  = 1'b1;
                                c_wst    = c_fst;
                                n_fail   = fail_adj(c_old, c_fst, r_fail);
                                n_status = c_fst;
                            end else begin
                                n_busy   = 1'b1;
                                n_vchunk = c_addr;
                            end
                        end
                    end
                    OP_HASH: begin
                        n_status = c_old;
                        if (r_fin) begin
                            c_waddr = r_vchunk;
                            if (rd_hash == 64'd0) begin
                                c_we_hash = 1'b1;
                                c_whash   = r_acc;
                            end
                            c_fst    = (rd_hash == 64'd0 || rd_hash == r_acc) ?
                                       ST_VERIFIED : ST_FAILED;
                            c_we_st  = 1'b1;
                            c_wst    = c_fst;
                            n_fail   = fail_adj(c_old, c_fst, r_fail);
                            n_status = c_fst;
                            n_busy   = 1'b0;
                        end
                    end
                    default: n_status = c_inrange ? c_old : ST_UNVERIFIED;
                endcase
            end
            S_SRCH_RD: begin
                if (r_lo < r_hi) begin
                    n_mid   = r_lo + ((r_hi - r_lo) >> 1);
                    c_raddr = AW'(n_mid);
                    n_state = S_SRCH_CMP;
                end else begin
                    n_mid   = r_lo;
                    n_state = S_WALK_RD;
                end
            end
            S_SRCH_CMP: begin
                if (rd_end <= r_cmd.rstart) n_lo = r_mid + CW'(1);
                else n_hi = r_mid;
                n_state = S_SRCH_RD;
            end
            S_WALK_RD: begin
                // r_mid carries the walk index here
                if (r_mid < c_n) begin
                    c_raddr = AW'(r_mid);
                    n_state = S_WALK_CHK;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_WALK_CHK: begin
                c_waddr = AW'(r_mid);
                if (rd_start > r_lastaddr) begin
                    n_state = S_DONE;
                end else begin
                    if (c_old != ST_UNVERIFIED) begin
                        c_we_st  = 1'b1;
                        c_wst    = ST_UNVERIFIED;
                        n_fail   = fail_adj(c_old, ST_UNVERIFIED, r_fail);
                        n_resets = r_resets + 9'd1;
                    end
                    n_mid   = r_mid + CW'(1);
                    n_state = S_WALK_RD;
                end
            end
            S_DONE: begin
                if (!r_ov || o_rsp.ready) begin
                    n_ov     = 1'b1;
                    n_o_st   = r_status;
                    n_o_fail = r_fail;
                    n_o_hash = r_acc;
                    n_o_rst  = r_resets;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fail   <= 9'd0;
            r_acc    <= FNV_BASIS;
            r_vchunk <= '0;
            r_busy   <= 1'b0;
            r_fin    <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fail   <= n_fail;
            r_acc    <= n_acc;
            r_vchunk <= n_vchunk;
            r_busy   <= n_busy;
            r_fin    <= n_fin;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_mid      <= n_mid;
        r_lastaddr <= n_lastaddr;
        r_resets   <= n_resets;
        r_status   <= n_status;
        r_o_st     <= n_o_st;
        r_o_fail   <= n_o_fail;
        r_o_hash   <= n_o_hash;
        r_o_rst    <= n_o_rst;
    end

    assign o_rsp.valid         = r_ov;
    assign o_rsp.chunk_status  = r_o_st;
    assign o_rsp.failed_total  = r_o_fail;
    assign o_rsp.computed_hash = r_o_hash;
    assign o_rsp.reset_chunks  = r_o_rst;

    a_fail_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_fail) <= MAXC)
        else $error("failure count above table size");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd_valid && o_cmd_ready) |-> (r_state == S_IDLE))
        else $error("command taken while sequencer busy");

    a_done_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (!r_ov || o_rsp.ready)) |=> (r_ov && r_state == S_IDLE))
        else $error("finished request did not reach response register");

endmodule

`default_nettype wire
